// File: rtl/mcc_pkg.sv
// Package for the mnemonic checksum check block: payload types, FSM states,
// SHA-256 constants and round helper functions. No dependencies.
package mcc_pkg;

  localparam int WordBits  = 11;
  localparam int WordCount = 12;
  localparam int PosBits   = 4;
  localparam int RoundCount = 64;
  localparam int RoundBits  = 6;

  typedef struct packed {
    logic [WordBits-1:0] word_index;
    logic                mnemonic_start;
  } in_item_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [3:0]  stored_checksum;
    logic [3:0]  computed_checksum;
    logic [63:0] entropy_high;
    logic [63:0] entropy_low;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_HASH,
    ST_OUTPUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       store_word;
    logic       load_hash;
    logic       round_step;
    logic [RoundBits-1:0] round_num;
    logic       load_result;
  } dp_cmd_t;

  function automatic logic [31:0] round_k(input logic [RoundBits-1:0] i);
    logic [31:0] k [0:63];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  localparam logic [255:0] StartH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] PadWord = 32'h8000_0000;
  localparam logic [31:0] LenWord = 32'd128;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// File: rtl/mnemonic_checksum_check_core.sv
// Top level of the mnemonic checksum check: controller plus datapath.
// Depends on mcc_pkg, mcc_ctrl and mcc_datapath.
//
//   channel | signals                        | payload
//   in      | in_valid / in_ready            | mcc_pkg::in_item_t
//   out     | out_valid / out_ready          | mcc_pkg::out_item_t
//
// Words 1..11 are stored as they are accepted. The twelfth word starts the
// rounds of the single shared SHA-256 round unit, then the result is held
// until taken; input is not accepted during hashing or while the result waits.
// Reset clears the slot counter and FSM; stored words are not cleared.
module mnemonic_checksum_check_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mcc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mcc_pkg::out_item_t  out_data
);
  import mcc_pkg::*;

  dp_cmd_t cmd;
  logic [PosBits-1:0] word_pos;

  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_start  (in_data.mnemonic_start),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word_pos  (word_pos),
    .cmd       (cmd)
  );

  mcc_datapath u_dp (
    .clk        (clk),
    .word_index (in_data.word_index),
    .word_pos   (word_pos),
    .cmd        (cmd),
    .result     (out_data)
  );
endmodule

// File: rtl/mcc_ctrl.sv
// Controller FSM for the mnemonic checksum check: word slot counter,
// round counter and handshake. Depends on mcc_pkg.
module mcc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_start,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [mcc_pkg::PosBits-1:0] word_pos,
  output mcc_pkg::dp_cmd_t cmd
);
  import mcc_pkg::*;

  state_t state, state_next;
  logic [PosBits-1:0]   pos, pos_next;
  logic [RoundBits-1:0] round, round_next;
  logic [PosBits-1:0]   slot;
  logic                 accept;

  assign accept = in_valid && in_ready;
  assign slot   = in_start ? '0 : pos;
  assign word_pos = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      pos   <= '0;
      round <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      round <= round_next;
    end
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    round_next = round;
    case (state)
      ST_COLLECT: begin
        if (accept) begin
          if (slot == PosBits'(WordCount - 1)) begin
            pos_next   = '0;
            round_next = '0;
            state_next = ST_HASH;
          end else begin
            pos_next = slot + PosBits'(1);
          end
        end
      end
      ST_HASH: begin
        round_next = round + RoundBits'(1);
        if (round == RoundBits'(RoundCount - 1)) state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (out_ready) state_next = ST_COLLECT;
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    cmd.round_num = round;
    case (state)
      ST_COLLECT: begin
        in_ready = 1'b1;
        cmd.store_word = accept;
        cmd.load_hash  = accept && (slot == PosBits'(WordCount - 1));
      end
      ST_HASH: begin
        cmd.round_step  = 1'b1;
        cmd.load_result = (round == RoundBits'(RoundCount - 1));
      end
      ST_OUTPUT: out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

// File: rtl/mcc_datapath.sv
// Datapath for the mnemonic checksum check: word registers, message schedule
// shift window and one SHA-256 round per cycle. Depends on mcc_pkg.
module mcc_datapath (
  input  logic              clk,
  input  logic [mcc_pkg::WordBits-1:0] word_index,
  input  logic [mcc_pkg::PosBits-1:0]  word_pos,
  input  mcc_pkg::dp_cmd_t  cmd,
  output mcc_pkg::out_item_t result
);
  import mcc_pkg::*;

  logic [WordBits-1:0] words [WordCount];
  logic [WordBits*WordCount-1:0] packed_bits;
  logic [WordBits*WordCount-1:0] next_bits;
  logic [511:0] sched;
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;
  logic [31:0]  s0, s1, w_new, t1, t2;
  logic [3:0]   stored_nib;
  // entropy kept aside since the schedule window shifts it out
  logic [127:0] sched_ent;

  always_comb begin
    for (int i = 0; i < WordCount; i++)
      packed_bits[WordBits*(WordCount-1-i) +: WordBits] = words[i];
    next_bits = packed_bits;
    // twelfth word arrives in the same cycle as the hash load
    next_bits[WordBits-1:0] = word_index;
  end

  always_ff @(posedge clk) begin
    if (cmd.store_word) words[word_pos] <= word_index;
  end

  // schedule window: sched[511:480] is w[t]
  always_comb begin
    s0 = rotr(sched[479:448], 7) ^ rotr(sched[479:448], 18) ^ (sched[479:448] >> 3);
    s1 = rotr(sched[63:32], 17) ^ rotr(sched[63:32], 19) ^ (sched[63:32] >> 10);
    w_new = sched[511:480] + s0 + sched[223:192] + s1;
    t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg))
         + round_k(cmd.round_num) + sched[511:480];
    t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hash) begin
      sched <= {next_bits[131:4], PadWord, 320'd0, LenWord};
      {va, vb, vc, vd, ve, vf, vg, vh} <= StartH;
      stored_nib <= next_bits[3:0];
    end else if (cmd.round_step) begin
      sched <= {sched[479:0], w_new};
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
    end
    if (cmd.load_result) begin
      result.stored_checksum   <= stored_nib;
      result.computed_checksum <= 4'((t1 + t2 + StartH[255:224]) >> 28);
      result.checksum_ok       <= (stored_nib == 4'((t1 + t2 + StartH[255:224]) >> 28));
      result.entropy_high      <= sched_ent[127:64];
      result.entropy_low       <= sched_ent[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hash) sched_ent <= next_bits[131:4];
  end
endmodule
